FILE: src/biquadratic_escape_time_top_macros.svh
// Assertion macros shared by the escape-time block.
`ifndef BIQUADRATIC_ESCAPE_TIME_TOP_MACROS_SVH
`define BIQUADRATIC_ESCAPE_TIME_TOP_MACROS_SVH

// Implication check, sampled on the rising clock edge and idle during reset.
`define BET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen.
`define BET_ASSERT_NEVER(lbl, cond, msg) \
  `BET_ASSERT(lbl, !(cond), msg)

`endif

FILE: src/bet_pkg.sv
// Shared constants, types and arithmetic helpers of the escape-time block.
package bet_pkg;

  localparam int FRAC_BITS = 28;
  localparam int IN_W      = 32;
  localparam int VAL_W     = 38;
  localparam int CNT_W     = 10;
  localparam int MAG_W     = VAL_W;
  localparam int DIGIT_W   = 10;
  localparam int NUM_CELLS = (MAG_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIG_TOT_W = NUM_CELLS * DIGIT_W;
  localparam int PROD_W    = 2 * MAG_W;

  localparam logic [VAL_W-1:0] VAL_MAX      = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN      = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] ESCAPE_BOUND = VAL_W'(10) << FRAC_BITS;
  localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(100);

  // One stage of the squaring chain: the operand, the multiplier digits
  // still to be consumed, and the running partial product.
  typedef struct packed {
    logic                 vld;
    logic [MAG_W-1:0]     mag;
    logic [DIG_TOT_W-1:0] digits;
    logic [PROD_W-1:0]    acc;
  } cell_data_t;

  // Two's complement sum of a 38-bit value and a 32-bit value, saturated.
  function automatic logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] x, logic [IN_W-1:0] y);
    logic [VAL_W:0] s;
    s = {x[VAL_W-1], x} + {{(VAL_W+1-IN_W){y[IN_W-1]}}, y};
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return s[VAL_W-1:0];
  endfunction

  // Magnitude of a signed 38-bit value; the most negative value maps to 2^37.
  function automatic logic [MAG_W-1:0] abs_mag(logic [VAL_W-1:0] x);
    return x[VAL_W-1] ? MAG_W'(~x + VAL_W'(1)) : MAG_W'(x);
  endfunction

endpackage

FILE: src/bet_cell.sv
// One cell of the squaring chain: consumes one multiplier digit per cycle.
module bet_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bet_pkg::cell_data_t cell_i,
  output bet_pkg::cell_data_t cell_o
);
  import bet_pkg::*;

  logic                         vld_q;
  logic [MAG_W-1:0]             mag_q;
  logic [DIG_TOT_W-1:0]         digits_q, digits_d;
  logic [PROD_W-1:0]            acc_q, acc_d;
  logic [DIGIT_W-1:0]           digit;
  logic [MAG_W+DIGIT_W-1:0]     part_prod;

  // Most significant digit first, so the running sum shifts up one digit.
  always_comb begin
    digit     = cell_i.digits[DIG_TOT_W-1 -: DIGIT_W];
    part_prod = cell_i.mag * digit;
    acc_d     = (cell_i.acc << DIGIT_W) + PROD_W'(part_prod);
    digits_d  = cell_i.digits << DIGIT_W;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= cell_i.mag;
    digits_q <= digits_d;
    acc_q    <= acc_d;
  end

  assign cell_o = '{vld: vld_q, mag: mag_q, digits: digits_q, acc: acc_q};

endmodule

FILE: src/bet_square.sv
// Fixed-point squarer: a chain of digit cells followed by shift and saturation.
module bet_square (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      issue_vld_i,
  input  logic [bet_pkg::MAG_W-1:0] mag_i,
  output logic                      sq_vld_o,
  output logic [bet_pkg::VAL_W-1:0] sq_o
);
  import bet_pkg::*;

  cell_data_t         chain [NUM_CELLS+1];
  logic [PROD_W-1:0]  shifted;
  logic [VAL_W-1:0]   sq_d, sq_q;
  logic               sq_vld_q;

  assign chain[0] = '{vld: issue_vld_i, mag: mag_i, digits: DIG_TOT_W'(mag_i), acc: '0};

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    bet_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // The square is never negative, so only the upper limit can be hit.
  always_comb begin
    shifted = chain[NUM_CELLS].acc >> FRAC_BITS;
    if (|shifted[PROD_W-1:VAL_W-1]) begin
      sq_d = VAL_MAX;
    end else begin
      sq_d = {1'b0, shifted[VAL_W-2:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= chain[NUM_CELLS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_vld_o = sq_vld_q;
  assign sq_o     = sq_q;

endmodule

FILE: src/biquadratic_escape_time_top.sv
// Top level of the escape-time test for the real map x -> (x^2 + a)^2 + b.
// Each square passes an issue register, 4 digit cells and a saturation register.
// One iteration needs two dependent squares. The block works on one point at a time: the next
// word is taken only once the result of the last one is registered and the block is idle again.
// Reset (asynchronous, active low) idles the block, sets the limit to 100, clears the result valid.
module biquadratic_escape_time_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bet_pkg::CNT_W-1:0]          cfg_max_iterations_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [bet_pkg::IN_W-1:0]    param_a_i,
  input  logic signed [bet_pkg::IN_W-1:0]    param_b_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               both_bounded_o,
  output logic [bet_pkg::CNT_W-1:0]          count_o,
  output logic                               from_second_orbit_o
);
  import bet_pkg::*;
  `include "biquadratic_escape_time_top_macros.svh"

  // Sequencer states. WAIT_CHECK waits for x^2 of the current orbit value,
  // which decides whether the orbit goes on; WAIT_MAP waits for (x^2 + a)^2.
  localparam logic [1:0] S_IDLE       = 2'd0;
  localparam logic [1:0] S_WAIT_CHECK = 2'd1;
  localparam logic [1:0] S_WAIT_MAP   = 2'd2;
  localparam logic [1:0] S_DONE       = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  max_iter_q;
  logic [IN_W-1:0]   a_q, a_d, b_q, b_d;
  logic              orbit_sel_q, orbit_sel_d;
  logic [CNT_W-1:0]  iter_cnt_q, iter_cnt_d;
  logic [CNT_W-1:0]  first_cnt_q, first_cnt_d;
  logic              mul_vld_q, mul_vld_d;
  logic [MAG_W-1:0]  mul_mag_q, mul_mag_d;
  logic              sq_vld;
  logic [VAL_W-1:0]  sq_val;
  logic              out_vld_q, out_vld_d;
  logic              out_both_q, out_both_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic              out_second_q, out_second_d;
  logic              out_free;

  // The limit register takes a word only while no point is being worked on.
  // A pending limit word wins over a new point at the same edge.
  assign cfg_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_iter_q <= cfg_max_iterations_i;
    end
  end

  // The squarer holds at most one operand at a time, since every square
  // depends on the one before it.
  bet_square u_square (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_vld_i (mul_vld_q),
    .mag_i       (mul_mag_q),
    .sq_vld_o    (sq_vld),
    .sq_o        (sq_val)
  );

  // The output register decouples the two sides: a new point is taken
  // while the last result still waits for the consumer.
  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && !cfg_valid_i;

  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    orbit_sel_d  = orbit_sel_q;
    iter_cnt_d   = iter_cnt_q;
    first_cnt_d  = first_cnt_q;
    mul_vld_d    = 1'b0;
    mul_mag_d    = mul_mag_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_both_d   = out_both_q;
    out_cnt_d    = out_cnt_q;
    out_second_d = out_second_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          // The first orbit starts at zero, whose square is zero.
          a_d         = param_a_i;
          b_d         = param_b_i;
          orbit_sel_d = 1'b0;
          iter_cnt_d  = '0;
          mul_vld_d   = 1'b1;
          mul_mag_d   = '0;
          state_d     = S_WAIT_CHECK;
        end
      end
      S_WAIT_CHECK: begin
        if (sq_vld) begin
          if (iter_cnt_q < max_iter_q && sq_val < ESCAPE_BOUND) begin
            mul_vld_d = 1'b1;
            mul_mag_d = abs_mag(sat_add(sq_val, a_q));
            state_d   = S_WAIT_MAP;
          end else if (!orbit_sel_q) begin
            // First orbit finished; the second one starts at b.
            first_cnt_d = iter_cnt_q;
            orbit_sel_d = 1'b1;
            iter_cnt_d  = '0;
            mul_vld_d   = 1'b1;
            mul_mag_d   = abs_mag({{(VAL_W-IN_W){b_q[IN_W-1]}}, b_q});
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_WAIT_MAP: begin
        if (sq_vld) begin
          // New orbit value is sat((x^2 + a)^2 + b); only its square is needed next.
          mul_vld_d  = 1'b1;
          mul_mag_d  = abs_mag(sat_add(sq_val, b_q));
          iter_cnt_d = iter_cnt_q + CNT_W'(1);
          state_d    = S_WAIT_CHECK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (iter_cnt_q >= max_iter_q && first_cnt_q >= max_iter_q) begin
            out_both_d   = 1'b1;
            out_cnt_d    = '0;
            out_second_d = 1'b0;
          end else if (iter_cnt_q < first_cnt_q) begin
            out_both_d   = 1'b0;
            out_cnt_d    = first_cnt_q;
            out_second_d = 1'b0;
          end else begin
            out_both_d   = 1'b0;
            out_cnt_d    = iter_cnt_q;
            out_second_d = 1'b1;
          end
          orbit_sel_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      orbit_sel_q <= 1'b0;
      iter_cnt_q  <= '0;
      first_cnt_q <= '0;
      mul_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      orbit_sel_q <= orbit_sel_d;
      iter_cnt_q  <= iter_cnt_d;
      first_cnt_q <= first_cnt_d;
      mul_vld_q   <= mul_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    mul_mag_q    <= mul_mag_d;
    out_both_q   <= out_both_d;
    out_cnt_q    <= out_cnt_d;
    out_second_q <= out_second_d;
  end

  assign out_valid_o         = out_vld_q;
  assign both_bounded_o      = out_both_q;
  assign count_o             = out_cnt_q;
  assign from_second_orbit_o = out_second_q;

  `BET_ASSERT(a_sq_latency, mul_vld_q |-> ##5 sq_vld, "square result did not arrive on time")
  `BET_ASSERT(a_single_issue, mul_vld_q |=> !mul_vld_q, "second square issued while one in flight")
  `BET_ASSERT_NEVER(a_sq_unexpected, sq_vld && (state_q == S_IDLE || state_q == S_DONE),
                    "square result arrived with no orbit waiting")
  `BET_ASSERT(a_cnt_limit, (state_q != S_IDLE) |-> (iter_cnt_q <= max_iter_q),
              "iteration count passed the limit")
  `BET_ASSERT(a_bounded_word, (out_valid_o && both_bounded_o) |->
              (count_o == '0 && !from_second_orbit_o), "bounded result carries a count")

endmodule

FILE: tb/tb_biquadratic_escape_time_top.sv
// Self-checking testbench for the escape-time block: directed table, then random phases.
module tb_biquadratic_escape_time_top;

  localparam int IN_W      = bet_pkg::IN_W;
  localparam int VAL_W     = bet_pkg::VAL_W;
  localparam int CNT_W     = bet_pkg::CNT_W;
  localparam int FRAC_BITS = bet_pkg::FRAC_BITS;

  // Signed limits of the 38-bit intermediates and the escape threshold on x^2.
  localparam longint VAL_HI      = (longint'(1) <<< (VAL_W - 1)) - 1;
  localparam longint VAL_LO      = -(longint'(1) <<< (VAL_W - 1));
  localparam longint ESCAPE_SQ   = longint'(10) <<< FRAC_BITS;

  // A few Q3.28 points that are easy to reason about.
  localparam logic [IN_W-1:0] P_MAX   = 32'h7FFF_FFFF;
  localparam logic [IN_W-1:0] P_MIN   = 32'h8000_0000;
  localparam logic [IN_W-1:0] P_ZERO  = 32'h0000_0000;
  localparam logic [IN_W-1:0] P_HALF  = 32'h0800_0000;
  localparam logic [IN_W-1:0] P_NEG_1 = 32'hF000_0000;
  localparam logic [IN_W-1:0] P_NEG_2 = 32'hE000_0000;
  localparam logic [IN_W-1:0] P_THREE = 32'h3000_0000;

  // The run is stopped here if it hangs; the slowest legal run is far below it.
  localparam int unsigned CYCLE_LIMIT = 8_000_000;

  typedef struct packed {
    logic             both_bounded;
    logic [CNT_W-1:0] count;
    logic             from_second_orbit;
  } escape_verdict_t;

  // Verdicts that can be read straight off the map.
  localparam escape_verdict_t BOUNDED        = '{1'b1, 10'd0, 1'b0};
  localparam escape_verdict_t ONE_STEP_FIRST = '{1'b0, 10'd1, 1'b0};
  localparam escape_verdict_t FROM_PREDICTOR = '0;

  // One row of the directed table. When fixed_want is set the verdict in the row is
  // used as the expectation, otherwise the predictor supplies it.
  typedef struct packed {
    logic [CNT_W-1:0] limit;
    logic [IN_W-1:0]  a;
    logic [IN_W-1:0]  b;
    logic             fixed_want;
    escape_verdict_t  want;
  } stim_row_t;

  localparam int NUM_DIRECTED = 22;
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // Reset limit of 100. The origin is a fixed point of both orbits.
    '{10'd100,  P_ZERO,       P_ZERO,       1'b1, BOUNDED},
    // Extreme parameters: orbit one escapes after one step, orbit two at once.
    '{10'd100,  P_MAX,        P_MAX,        1'b1, ONE_STEP_FIRST},
    '{10'd100,  P_MIN,        P_MIN,        1'b1, ONE_STEP_FIRST},
    '{10'd100,  P_MAX,        P_MIN,        1'b0, FROM_PREDICTOR},
    '{10'd100,  P_MIN,        P_MAX,        1'b0, FROM_PREDICTOR},
    // Orbits that swap between 0 and 1, or between 0 and -1, never escape.
    '{10'd100,  P_NEG_1,      P_ZERO,       1'b1, BOUNDED},
    '{10'd100,  P_ZERO,       P_NEG_1,      1'b1, BOUNDED},
    // Slow escape, equal counts on both orbits, and starts right at the bound.
    '{10'd100,  P_ZERO,       P_HALF,       1'b0, FROM_PREDICTOR},
    '{10'd100,  P_NEG_2,      P_ZERO,       1'b0, FROM_PREDICTOR},
    '{10'd100,  P_ZERO,       P_THREE,      1'b0, FROM_PREDICTOR},
    '{10'd100,  P_ZERO,       32'h3298_B075, 1'b0, FROM_PREDICTOR},
    '{10'd100,  P_ZERO,       32'h3298_B076, 1'b0, FROM_PREDICTOR},
    '{10'd100,  32'h0000_0001, 32'hFFFF_FFFF, 1'b0, FROM_PREDICTOR},
    '{10'd100,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, FROM_PREDICTOR},
    // A zero limit lets neither orbit step, so everything is bounded.
    '{10'd0,    32'h1234_5678, 32'hFFFF_FFFB, 1'b1, BOUNDED},
    '{10'd0,    P_MAX,        P_MAX,        1'b1, BOUNDED},
    // A limit of one.
    '{10'd1,    P_ZERO,       P_ZERO,       1'b1, BOUNDED},
    '{10'd1,    P_MAX,        P_MAX,        1'b1, ONE_STEP_FIRST},
    '{10'd1,    P_NEG_2,      P_ZERO,       1'b0, FROM_PREDICTOR},
    // Largest limit: bounded orbits run the full 1023 steps each.
    '{10'd1023, P_ZERO,       P_ZERO,       1'b1, BOUNDED},
    '{10'd1023, P_NEG_1,      P_ZERO,       1'b1, BOUNDED},
    '{10'd1023, 32'hE800_0000, P_ZERO,      1'b0, FROM_PREDICTOR}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CNT_W-1:0]       cfg_max_iterations_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic signed [IN_W-1:0] param_a_i = '0;
  logic signed [IN_W-1:0] param_b_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   both_bounded_o;
  logic [CNT_W-1:0]       count_o;
  logic                   from_second_orbit_o;

  // Predictor copy of the limit register, verdicts still owed by the block,
  // and the error tally.
  int unsigned       escape_limit = 100;
  escape_verdict_t   escape_verdicts_q[$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;

  // Per-phase switches that turn off the random gaps on either side.
  bit steady_source = 1'b0;
  bit steady_sink = 1'b0;

  biquadratic_escape_time_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_max_iterations_i (cfg_max_iterations_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .param_a_i            (param_a_i),
    .param_b_i            (param_b_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .both_bounded_o       (both_bounded_o),
    .count_o              (count_o),
    .from_second_orbit_o  (from_second_orbit_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog. A correct run finishes long before this count is reached.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Saturate a sum to the signed 38-bit range.
  function automatic longint clamp_val(longint v);
    if (v > VAL_HI) return VAL_HI;
    if (v < VAL_LO) return VAL_LO;
    return v;
  endfunction

  // Exact square shifted down by the fraction width. The product is never
  // negative, so the shift truncates toward zero. Anything at or above 2^37
  // saturates to the largest positive value.
  function automatic longint square_q(longint v);
    logic [VAL_W-1:0]   mag;
    logic [2*VAL_W-1:0] prod;
    mag  = (v < 0) ? VAL_W'(-v) : VAL_W'(v);
    prod = {{VAL_W{1'b0}}, mag} * {{VAL_W{1'b0}}, mag};
    prod = prod >> FRAC_BITS;
    if (|prod[2*VAL_W-1:VAL_W-1]) return VAL_HI;
    return longint'(prod[VAL_W-2:0]);
  endfunction

  // Steps taken by one orbit of x -> (x^2 + a)^2 + b before x^2 reaches the
  // bound or the limit runs out.
  function automatic int unsigned orbit_steps(longint start, longint a, longint b,
                                              int unsigned limit);
    longint      x;
    longint      sq;
    int unsigned n;
    x  = clamp_val(start);
    sq = square_q(x);
    n  = 0;
    while (n < limit && sq < ESCAPE_SQ) begin
      x  = clamp_val(square_q(clamp_val(sq + a)) + b);
      sq = square_q(x);
      n++;
    end
    return n;
  endfunction

  // Verdict for one point under the current limit. Orbit one starts at zero,
  // orbit two at b. Ties between the two counts go to the second orbit.
  function automatic escape_verdict_t predict_escape_verdict(logic signed [IN_W-1:0] a,
                                                             logic signed [IN_W-1:0] b);
    longint          a_q;
    longint          b_q;
    int unsigned     first_steps;
    int unsigned     second_steps;
    escape_verdict_t v;
    a_q          = a;
    b_q          = b;
    first_steps  = orbit_steps(0, a_q, b_q, escape_limit);
    second_steps = orbit_steps(b_q, a_q, b_q, escape_limit);
    v = '0;
    if (first_steps >= escape_limit && second_steps >= escape_limit) begin
      v.both_bounded = 1'b1;
    end else if (second_steps < first_steps) begin
      v.count = CNT_W'(first_steps);
    end else begin
      v.count             = CNT_W'(second_steps);
      v.from_second_orbit = 1'b1;
    end
    return v;
  endfunction

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Result side. Before every word the sink may hold ready low for a random
  // number of cycles, so stalls land at all points of the block's work. The
  // word is taken at the rising edge where valid and ready are both high,
  // and compared field by field with the oldest pending verdict.
  initial begin
    int unsigned     stall;
    escape_verdict_t want;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = steady_sink ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (escape_verdicts_q.size() == 0) begin
        // A word with no point outstanding: one word seen where none was owed.
        report_mismatch("unowed result word", 1, 0);
      end else begin
        want = escape_verdicts_q.pop_front();
        if (both_bounded_o !== want.both_bounded)
          report_mismatch("both_bounded", both_bounded_o, want.both_bounded);
        if (count_o !== want.count)
          report_mismatch("count", count_o, want.count);
        if (from_second_orbit_o !== want.from_second_orbit)
          report_mismatch("from_second_orbit", from_second_orbit_o, want.from_second_orbit);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  // Offer one point after a random gap and hold it until it is taken. The
  // verdict is queued on the edge where the word is accepted. Valid stays
  // high on return, so the caller's next action must come at the next
  // falling edge.
  task automatic send_point(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
                            input escape_verdict_t verdict);
    int unsigned gap;
    @(negedge clk_i);
    gap = steady_source ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    param_a_i  <= a;
    param_b_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    escape_verdicts_q.push_back(verdict);
  endtask

  // Change the limit only while the block is idle: the input side is closed
  // first, then every outstanding verdict must have been collected. Each
  // point always yields a word, so an empty queue means the block is idle.
  task automatic write_escape_limit(input int unsigned limit);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (escape_verdicts_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i          <= 1'b1;
    cfg_max_iterations_i <= CNT_W'(limit);
    do @(posedge clk_i); while (!cfg_ready_o);
    escape_limit = limit;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    stim_row_t              row;
    escape_verdict_t        verdict;
    logic signed [IN_W-1:0] a;
    logic signed [IN_W-1:0] b;
    int unsigned            limit;
    int unsigned            points;

    // Reset is held at the start and released on a falling edge.
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. The limit changes only where a row asks for it.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.limit != escape_limit) write_escape_limit(row.limit);
      verdict = row.fixed_want ? row.want : predict_escape_verdict(row.a, row.b);
      send_point(row.a, row.b, verdict);
    end

    // Random phases. Most use small limits to keep bounded orbits cheap; one
    // phase uses the full limit with a handful of points and one a zero limit.
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        3: begin
          limit  = 1023;
          points = 8;
        end
        7: begin
          limit  = 0;
          points = 60;
        end
        0, 5: begin
          limit  = 100;
          points = 100;
        end
        default: begin
          limit  = $urandom_range(1, 40);
          points = 150;
        end
      endcase
      write_escape_limit(limit);
      steady_source = ($urandom_range(0, 3) == 0);
      steady_sink   = ($urandom_range(0, 3) == 0);
      repeat (points) begin
        // Half of the points sit in the region where orbits live long; the
        // rest are full-range words, corner values and tiny values.
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            a = $urandom;
            b = $urandom;
          end
          8: begin
            a = $urandom_range(0, 1) ? P_MAX : P_MIN;
            b = $urandom_range(0, 1) ? P_ZERO : IN_W'($urandom);
          end
          9: begin
            a = $urandom_range(0, 1) ? P_NEG_1 : IN_W'($urandom);
            b = IN_W'($urandom_range(0, 4095)) - IN_W'(2048);
          end
          default: begin
            a = IN_W'($urandom_range(0, 32'h4000_0000)) - 32'h3000_0000;
            b = IN_W'($urandom_range(0, 32'h3000_0000)) - 32'h2000_0000;
          end
        endcase
        send_point(a, b, predict_escape_verdict(a, b));
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then give a stray extra word some time to show up.
    while (escape_verdicts_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
